// ===== src/cea_pkg.sv =====
// Package: shared widths, codes, item type and saturation helper for the complex ALU.
`default_nettype none
package cea_pkg;

  localparam int COMP_WIDTH = 16;
  localparam int FRAC_BITS  = 12;
  localparam int W  = COMP_WIDTH;
  localparam int MW = 2 * COMP_WIDTH;          // product and sum magnitude width
  localparam int DW = 2 * COMP_WIDTH;          // divisor width
  localparam int QB = COMP_WIDTH + 2;          // quotient bits incl. one rounding bit
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam logic [1:0] K_ADD = 2'd0;
  localparam logic [1:0] K_SUB = 2'd1;
  localparam logic [1:0] K_MUL = 2'd2;
  localparam logic [1:0] K_DIV = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_SAT  = 2'd1;
  localparam logic [1:0] ST_DIVZ = 2'd2;

  localparam logic [W-1:0] POS_MAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] NEG_MIN = {1'b1, {(W-1){1'b0}}};

  // one classified operand pair, as queued between front and back
  typedef struct packed {
    logic [1:0]          kind;
    logic                zero_div;
    logic                last;
    logic signed [W-1:0] ar;
    logic signed [W-1:0] ai;
    logic signed [W-1:0] br;
    logic signed [W-1:0] bi;
  } item_t;

  typedef struct packed {
    logic [W-1:0] v;
    logic         s;
  } sat_t;

  // clamp a sign/magnitude value to the result range
  function automatic sat_t sat_sm(input logic [MW:0] m, input logic neg);
    sat_t r;
    logic [MW:0] lim;
    lim = neg ? (MW+1)'(NEG_MIN) : (MW+1)'(POS_MAX);
    if (m > lim) begin
      r.v = neg ? NEG_MIN : POS_MAX;
      r.s = 1'b1;
    end else begin
      r.v = neg ? W'(-m[W-1:0]) : m[W-1:0];
      r.s = 1'b0;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== src/cea_front.sv =====
// Front end: input register that accepts beats and tags divide-by-zero.
`default_nettype none
module cea_front import cea_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [1:0]          kind,
  input  wire logic signed [W-1:0] a_re,
  input  wire logic signed [W-1:0] a_im,
  input  wire logic signed [W-1:0] b_re,
  input  wire logic signed [W-1:0] b_im,
  input  wire logic                last_in,
  input  wire logic                full,
  output logic                     push,
  output item_t                    push_item
);

  logic  held;
  item_t item;
  logic  load;

  // push the held beat whenever the queue has room
  assign push      = held && !full;
  assign load      = !held || push;
  assign in_stall  = !load;
  assign push_item = item;

  // advance valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (load) begin
      held <= in_valid;
    end
  end

  // capture and classify the beat
  always_ff @(posedge clk) begin
    if (load && in_valid) begin
      item.kind     <= kind;
      item.zero_div <= (b_re == '0) && (b_im == '0);
      item.last     <= last_in;
      item.ar       <= a_re;
      item.ai       <= a_im;
      item.br       <= b_re;
      item.bi       <= b_im;
    end
  end

endmodule
`default_nettype wire

// ===== src/cea_fifo.sv =====
// Short queue between front end and back end.
`default_nettype none
module cea_fifo import cea_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  item_t     push_item,
  output logic      full,
  input  wire logic pop,
  output item_t     pop_item,
  output logic      empty
);

  item_t              mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wptr;
  logic [FIFO_AW-1:0] rptr;
  logic [FIFO_AW:0]   count;

  assign full     = (count == (FIFO_AW+1)'(FIFO_DEPTH));
  assign empty    = (count == '0);
  assign pop_item = mem[rptr];

  // write the incoming beat
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_item;
    end
  end

  // advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop)  rptr <= rptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

`ifndef SYNTH
  a_no_overrun: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue push while full");
  a_no_underrun: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("queue pop while empty");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= (FIFO_AW+1)'(FIFO_DEPTH))
    else $error("queue count out of range");
`endif

endmodule
`default_nettype wire

// ===== src/cea_back.sv =====
// Back end: multiplier stage, sum stage, pipelined divider, rounding and saturation.
`default_nettype none
module cea_back import cea_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         empty,
  input  item_t             pop_item,
  output logic              pop,
  output logic              out_valid,
  input  wire logic         out_stall,
  output logic signed [W-1:0] c_re,
  output logic signed [W-1:0] c_im,
  output logic [1:0]        status,
  output logic              last_out
);

  localparam int NW = MW + FRAC_BITS + 1;
  localparam int CW = (NW > DW + QB) ? NW : DW + QB;

  typedef struct packed {
    logic [1:0]            kind;
    logic                  zero_div;
    logic                  last;
    logic                  ar_pos, ar_neg, ai_pos, ai_neg;
    logic signed [MW-1:0]  p_rr, p_ii, p_ir, p_ri, p_br, p_bi;
    logic signed [W-1:0]   ar, ai, br, bi;
  } mul_t;

  typedef struct packed {
    logic [1:0]   kind;
    logic         zero_div;
    logic         last;
    logic         ar_pos, ar_neg, ai_pos, ai_neg;
    logic         neg_re, neg_im;
    logic [MW-1:0] mag_re, mag_im;
    logic [DW-1:0] den;
    logic         ovf_re, ovf_im;
    logic [DW-1:0] rem_re, rem_im;
    logic [QB-1:0] nl_re, nl_im;
    logic [QB-1:0] q_re, q_im;
  } div_t;

  logic            ena;
  logic            v1;
  mul_t            s1;
  logic            v2;
  div_t            s2;
  logic [QB:0]     vd;
  div_t            sd [QB+1];
  div_t            d0;
  sat_t            r_re, r_im;
  logic [1:0]      st_next;
  logic            s2_neg_re, s2_neg_im;
  logic signed [MW:0] sum_re, sum_im;
  logic [DW-1:0]   den_next;
  logic [NW-1:0]   n_re, n_im;

  // one restoring-divide bit for both parts
  function automatic div_t div_step(input div_t d);
    div_t        r;
    logic [DW:0] t;
    r = d;
    t = {d.rem_re, d.nl_re[QB-1]};
    if (t >= {1'b0, d.den}) begin
      t = t - {1'b0, d.den};
      r.q_re = {d.q_re[QB-2:0], 1'b1};
    end else begin
      r.q_re = {d.q_re[QB-2:0], 1'b0};
    end
    r.rem_re = t[DW-1:0];
    r.nl_re  = {d.nl_re[QB-2:0], 1'b0};
    t = {d.rem_im, d.nl_im[QB-1]};
    if (t >= {1'b0, d.den}) begin
      t = t - {1'b0, d.den};
      r.q_im = {d.q_im[QB-2:0], 1'b1};
    end else begin
      r.q_im = {d.q_im[QB-2:0], 1'b0};
    end
    r.rem_im = t[DW-1:0];
    r.nl_im  = {d.nl_im[QB-2:0], 1'b0};
    return r;
  endfunction

  // finish one part: pick the result form for this kind
  function automatic sat_t finish(input logic [1:0] k, input logic [MW-1:0] m,
                                  input logic neg, input logic ovf,
                                  input logic [QB-1:0] q);
    sat_t        r;
    logic [MW:0] rm;
    case (k)
      K_ADD, K_SUB: rm = {1'b0, m};
      K_MUL: rm = ({1'b0, m} + (MW+1)'(1 << (FRAC_BITS - 1))) >> FRAC_BITS;
      K_DIV: rm = ovf ? {(MW+1){1'b1}} : (MW+1)'(({1'b0, q} + 1'b1) >> 1);
      default: rm = '0;
    endcase
    r = sat_sm(rm, neg);
    return r;
  endfunction

  assign ena = !out_valid || !out_stall;
  assign pop = ena && !empty;

  // form the signed sums of the sum stage
  always_comb begin
    case (s1.kind)
      K_ADD: begin
        sum_re = (MW+1)'(s1.ar) + (MW+1)'(s1.br);
        sum_im = (MW+1)'(s1.ai) + (MW+1)'(s1.bi);
      end
      K_SUB: begin
        sum_re = (MW+1)'(s1.ar) - (MW+1)'(s1.br);
        sum_im = (MW+1)'(s1.ai) - (MW+1)'(s1.bi);
      end
      K_MUL: begin
        sum_re = (MW+1)'(s1.p_rr) - (MW+1)'(s1.p_ii);
        sum_im = (MW+1)'(s1.p_ir) + (MW+1)'(s1.p_ri);
      end
      default: begin
        sum_re = (MW+1)'(s1.p_rr) + (MW+1)'(s1.p_ii);
        sum_im = (MW+1)'(s1.p_ir) - (MW+1)'(s1.p_ri);
      end
    endcase
    s2_neg_re = sum_re[MW];
    s2_neg_im = sum_im[MW];
    den_next  = DW'(unsigned'(s1.p_br)) + DW'(unsigned'(s1.p_bi));
  end

  // stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      vd <= '0;
      out_valid <= 1'b0;
    end else if (ena) begin
      v1 <= !empty;
      v2 <= v1;
      vd <= {vd[QB-1:0], v2};
      out_valid <= vd[QB];
    end
  end

  // multiplier stage
  always_ff @(posedge clk) begin
    if (ena) begin
      s1.kind     <= pop_item.kind;
      s1.zero_div <= pop_item.zero_div;
      s1.last     <= pop_item.last;
      s1.ar_pos   <= !pop_item.ar[W-1] && (pop_item.ar != '0);
      s1.ar_neg   <= pop_item.ar[W-1];
      s1.ai_pos   <= !pop_item.ai[W-1] && (pop_item.ai != '0);
      s1.ai_neg   <= pop_item.ai[W-1];
      s1.p_rr     <= pop_item.ar * pop_item.br;
      s1.p_ii     <= pop_item.ai * pop_item.bi;
      s1.p_ir     <= pop_item.ai * pop_item.br;
      s1.p_ri     <= pop_item.ar * pop_item.bi;
      s1.p_br     <= pop_item.br * pop_item.br;
      s1.p_bi     <= pop_item.bi * pop_item.bi;
      s1.ar       <= pop_item.ar;
      s1.ai       <= pop_item.ai;
      s1.br       <= pop_item.br;
      s1.bi       <= pop_item.bi;
    end
  end

  // sum stage: sign and magnitude, divisor
  always_ff @(posedge clk) begin
    if (ena) begin
      s2.kind     <= s1.kind;
      s2.zero_div <= s1.zero_div;
      s2.last     <= s1.last;
      s2.ar_pos   <= s1.ar_pos;
      s2.ar_neg   <= s1.ar_neg;
      s2.ai_pos   <= s1.ai_pos;
      s2.ai_neg   <= s1.ai_neg;
      s2.neg_re   <= s2_neg_re;
      s2.neg_im   <= s2_neg_im;
      s2.mag_re   <= s2_neg_re ? MW'(-sum_re) : sum_re[MW-1:0];
      s2.mag_im   <= s2_neg_im ? MW'(-sum_im) : sum_im[MW-1:0];
      s2.den      <= den_next;
      s2.ovf_re   <= 1'b0;
      s2.ovf_im   <= 1'b0;
      s2.rem_re   <= '0;
      s2.rem_im   <= '0;
      s2.nl_re    <= '0;
      s2.nl_im    <= '0;
      s2.q_re     <= '0;
      s2.q_im     <= '0;
    end
  end

  // divider setup: overflow check and initial remainder
  assign n_re = NW'(s2.mag_re) << (FRAC_BITS + 1);
  assign n_im = NW'(s2.mag_im) << (FRAC_BITS + 1);

  always_comb begin
    d0        = s2;
    d0.ovf_re = CW'(n_re) >= (CW'(s2.den) << QB);
    d0.ovf_im = CW'(n_im) >= (CW'(s2.den) << QB);
    d0.rem_re = DW'(n_re >> QB);
    d0.rem_im = DW'(n_im >> QB);
    d0.nl_re  = n_re[QB-1:0];
    d0.nl_im  = n_im[QB-1:0];
  end

  always_ff @(posedge clk) begin
    if (ena) begin
      sd[0] <= d0;
    end
  end

  // divider stages, one quotient bit each
  always_ff @(posedge clk) begin
    if (ena) begin
      for (int k = 1; k <= QB; k++) begin
        sd[k] <= div_step(sd[k-1]);
      end
    end
  end

  // round and saturate
  always_comb begin
    r_re = finish(sd[QB].kind, sd[QB].mag_re, sd[QB].neg_re, sd[QB].ovf_re, sd[QB].q_re);
    r_im = finish(sd[QB].kind, sd[QB].mag_im, sd[QB].neg_im, sd[QB].ovf_im, sd[QB].q_im);
    st_next = (r_re.s || r_im.s) ? ST_SAT : ST_OK;
  end

  // output register
  always_ff @(posedge clk) begin
    if (ena && vd[QB]) begin
      last_out <= sd[QB].last;
      if (sd[QB].kind == K_DIV && sd[QB].zero_div) begin
        c_re   <= sd[QB].ar_pos ? POS_MAX : (sd[QB].ar_neg ? NEG_MIN : '0);
        c_im   <= sd[QB].ai_pos ? POS_MAX : (sd[QB].ai_neg ? NEG_MIN : '0);
        status <= ST_DIVZ;
      end else begin
        c_re   <= r_re.v;
        c_im   <= r_im.v;
        status <= st_next;
      end
    end
  end

`ifndef SYNTH
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == ST_OK || status == ST_SAT || status == ST_DIVZ))
    else $error("bad status code");
  a_divz_parts: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_DIVZ) |->
      ((c_re == POS_MAX || c_re == NEG_MIN || c_re == '0) &&
       (c_im == POS_MAX || c_im == NEG_MIN || c_im == '0)))
    else $error("divide-by-zero result not a limit or zero");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(c_re) && $stable(c_im) &&
                                  $stable(status) && $stable(last_out)))
    else $error("stalled result beat changed");
`endif

endmodule
`default_nettype wire

// ===== src/complex_elementwise_alu_top.sv =====
// Top level: complex add/sub/mul/div unit with front end, queue and back end.
//
//  channel | signals                                     | direction
//  in      | in_valid, in_stall, kind, a_re..b_im, last_in | operand beats in
//  out     | out_valid, out_stall, c_re, c_im, status, last_out | result beats out
//
// One beat per cycle while out_stall is low; in the back end each beat passes the
// multiplier, sum, divider setup, one stage per quotient bit and output register.
// Every operation runs the same fixed-length pipeline, so results stay in order.
// rst is synchronous and clears only valid flags, queue pointers and queue count.
// out_stall freezes the back end; the queue and the input register absorb the slack.
`default_nettype none
module complex_elementwise_alu_top import cea_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [1:0]          kind,
  input  wire logic signed [W-1:0] a_re,
  input  wire logic signed [W-1:0] a_im,
  input  wire logic signed [W-1:0] b_re,
  input  wire logic signed [W-1:0] b_im,
  input  wire logic                last_in,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic signed [W-1:0]      c_re,
  output logic signed [W-1:0]      c_im,
  output logic [1:0]               status,
  output logic                     last_out
);

  logic  push, full, pop, empty;
  item_t push_item, pop_item;

  cea_front u_front (
    .clk, .rst, .in_valid, .in_stall, .kind, .a_re, .a_im, .b_re, .b_im,
    .last_in, .full, .push, .push_item
  );

  cea_fifo u_fifo (
    .clk, .rst, .push, .push_item, .full, .pop, .pop_item, .empty
  );

  cea_back u_back (
    .clk, .rst, .empty, .pop_item, .pop, .out_valid, .out_stall,
    .c_re, .c_im, .status, .last_out
  );

endmodule
`default_nettype wire
